>>> hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam logic [7:0] TEXT_COLOR_RESET = 8'd15;

    // Register index, taken from byte address bit 2.
    localparam logic CFG_TEXT_COLOR = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } t_result;

endpackage

>>> hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/text_console_writer.sv
`timescale 1ns / 1ps

// Text console engine with a screen store of ROWS x COLUMNS cells and a cursor.
// Input transactions carry func, char_code, read_row and read_col; each one
// yields exactly one output transaction with the cell bytes and the cursor.
// Put, newline, clear and unused codes push their result into a two-entry
// output queue at the same edge that accepts them. A read passes through
// ST_READ, which waits on the registered read port of the screen memory.
// A put or newline that moves below the last row starts a scroll that copies
// the store one cell a cycle through that memory port and then fills the
// bottom row with blanks in the text colour. A clear writes every cell once.
// Input is stalled during both sweeps.
// Input is also stalled while the output queue holds two transactions, so
// a stalled receiver holds the block after two pending results.
// Reset homes the cursor, sets text_color to 15 and empties the queue. The
// screen cells are undefined until written; software clears the screen first.
// text_color is written through the APB port at byte address 0.

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_read_row,
    input  logic [6:0]  i_read_col,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_color,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [7:0]         r_fill_color, n_fill_color;
    logic               r_rd_ok, n_rd_ok;
    logic [7:0]         r_text_color;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [15:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [15:0]        ram_rdata;

    t_result            r_q [2];
    logic               r_head;
    logic [1:0]         r_count;
    logic               push;
    t_result            push_data;
    logic               pop;
    logic               tail;
    logic               accept;
    logic               adv_row;
    logic [15:0]        blank;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_TEXT_COLOR) ? {24'd0, r_text_color} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == CFG_TEXT_COLOR)) begin
            r_text_color <= pwdata[7:0];
        end
    end

    assign o_in_stall = (r_state != ST_IDLE) || (r_count == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign blank      = {r_fill_color, SPACE_CODE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
            r_rd_ok <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_color <= n_fill_color;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_row        = r_row;
        n_col        = r_col;
        n_fill_color = r_fill_color;
        n_rd_ok      = r_rd_ok;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        push         = 1'b0;
        push_data    = '0;
        adv_row      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_PUT: begin
                            if (i_char_code == NEWLINE_CODE) begin
                                adv_row = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(32'(r_row) * COLUMNS + 32'(r_col));
                                ram_wdata = {r_text_color, i_char_code};
                                if (r_col == COL_W'(COLUMNS - 1)) begin
                                    adv_row = 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                            if (adv_row) begin
                                n_col = '0;
                                if (r_row == ROW_W'(ROWS - 1)) begin
                                    n_state      = ST_SCROLL;
                                    n_cnt        = '0;
                                    n_fill_color = r_text_color;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end
                            push                 = 1'b1;
                            push_data.cursor_row = 5'(n_row);
                            push_data.cursor_col = 7'(n_col);
                        end
                        FUNC_READ: begin
                            ram_raddr = AW'(32'(i_read_row) * COLUMNS + 32'(i_read_col));
                            n_rd_ok   = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);
                            n_state   = ST_READ;
                        end
                        FUNC_CLEAR: begin
                            n_row        = '0;
                            n_col        = '0;
                            n_cnt        = '0;
                            n_fill_color = r_text_color;
                            n_state      = ST_CLEAR;
                            push         = 1'b1;
                        end
                        default: begin
                            push                 = 1'b1;
                            push_data.cursor_row = 5'(r_row);
                            push_data.cursor_col = 7'(r_col);
                        end
                    endcase
                end
            end
            ST_READ: begin
                push                 = 1'b1;
                push_data.cell_char  = r_rd_ok ? ram_rdata[7:0] : 8'd0;
                push_data.cell_color = r_rd_ok ? ram_rdata[15:8] : 8'd0;
                push_data.cursor_row = 5'(r_row);
                push_data.cursor_col = 7'(r_col);
                n_state              = ST_IDLE;
            end
            ST_SCROLL: begin
                if (r_cnt != CW'(COPY_N)) begin
                    ram_raddr = AW'(32'(r_cnt) + COLUMNS);
                end
                if (r_cnt != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(32'(r_cnt) - 1);
                    ram_wdata = ram_rdata;
                end
                if (r_cnt == CW'(COPY_N)) begin
                    n_state = ST_FILL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(32'(r_cnt) + COPY_N);
                ram_wdata = blank;
                if (r_cnt == CW'(COLUMNS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cnt);
                ram_wdata = blank;
                if (r_cnt == CW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign pop  = (r_count != 2'd0) && !i_out_stall;
    assign tail = r_head ^ r_count[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (pop) begin
                r_head <= ~r_head;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[tail] <= push_data;
        end
    end

    assign o_out_valid  = (r_count != 2'd0);
    assign o_cell_char  = r_q[r_head].cell_char;
    assign o_cell_color = r_q[r_head].cell_color;
    assign o_cursor_row = r_q[r_head].cursor_row;
    assign o_cursor_col = r_q[r_head].cursor_col;

endmodule
